>>> sv/gspg_pkg.sv
// ----------------------------------------------------------------------------
// gspg_pkg
// Shared widths, constants, beat and command types, and state encodings for
// the graded segment point generator.
// ----------------------------------------------------------------------------
package gspg_pkg;

  localparam int MAX_POINTS       = 64;
  localparam int COORD_BITS       = 32;
  localparam int FACTOR_FRAC_BITS = 12;
  localparam int FACTOR_BITS      = 16;
  localparam int GUARD_BITS       = 62 - COORD_BITS;
  localparam int POW_BITS         = 48;
  localparam int COUNT_BITS       = 7;
  localparam int IDX_BITS         = 6;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int DIST_BITS        = 2 * DIFF_BITS + 1;
  localparam int DIVD_BITS        = DIFF_BITS + GUARD_BITS;
  localparam int DIVC_BITS        = $clog2(DIVD_BITS);
  // sum of powers is never below one, so the step fits in this many bits
  localparam int STEP_BITS        = DIVD_BITS - FACTOR_FRAC_BITS;
  localparam int STEP_LO_BITS     = STEP_BITS / 2 + 1;
  localparam int STEP_HI_BITS     = STEP_BITS - STEP_LO_BITS;
  localparam int SHIFT_BITS       = 5;

  localparam logic [POW_BITS-1:0]    POW_SAT    = {POW_BITS{1'b1}};
  localparam logic [POW_BITS-1:0]    POW_ONE    =
    {{(POW_BITS-1){1'b0}}, 1'b1} << FACTOR_FRAC_BITS;
  localparam logic [FACTOR_BITS-1:0] FACTOR_ONE =
    {{(FACTOR_BITS-1){1'b0}}, 1'b1} << FACTOR_FRAC_BITS;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = COUNT_BITS'(MAX_POINTS);
  localparam logic [COUNT_BITS-1:0]  COUNT_MIN  = COUNT_BITS'(2);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COUNT_BITS-1:0]        point_count;
    logic [FACTOR_BITS-1:0]       grading_factor;
    logic signed [COORD_BITS-1:0] pick_x;
    logic signed [COORD_BITS-1:0] pick_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [IDX_BITS-1:0]          point_index;
    logic                         point_valid;
    logic                         last;
  } out_beat_t;

  // classified segment handed from front to back
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [IDX_BITS-1:0]          count;
    logic [FACTOR_BITS-1:0]       factor;
    logic                         from_start;
    logic                         degen;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POWER,
    B_NORM,
    B_DIV,
    B_READ,
    B_MUL,
    B_SUM,
    B_OUT
  } back_state_t;

endpackage

>>> sv/gspg_front.sv
// ----------------------------------------------------------------------------
// gspg_front
// Accepts a segment beat, flags degenerate requests and picks the seeding
// direction by comparing squared pick distances, one square per cycle.
// ----------------------------------------------------------------------------
module gspg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gspg_pkg::in_beat_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output gspg_pkg::cmd_t     push_cmd
);

  gspg_pkg::front_state_t state, state_next;
  gspg_pkg::in_beat_t     item;
  logic signed [gspg_pkg::DIFF_BITS-1:0] diff [4];
  logic [1:0]                            sq_step;
  logic [gspg_pkg::DIST_BITS-1:0]        dist0, dist1;
  logic                                  degen;

  logic signed [gspg_pkg::DIFF_BITS-1:0] diff_sel;
  logic [gspg_pkg::DIFF_BITS-1:0]        diff_mag;
  logic [2*gspg_pkg::DIFF_BITS-1:0]      square;
  logic [gspg_pkg::COUNT_BITS-1:0]       count_sat;
  logic                                  accept;

  assign accept = in_valid && in_ready;

  // magnitude square of the selected difference
  always_comb begin
    diff_sel = diff[sq_step];
    diff_mag = diff_sel[gspg_pkg::DIFF_BITS-1] ? gspg_pkg::DIFF_BITS'(-diff_sel)
                                               : gspg_pkg::DIFF_BITS'(diff_sel);
    square   = diff_mag * diff_mag;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gspg_pkg::F_IDLE: begin
        if (accept) begin
          if (in_data.point_count <= gspg_pkg::COUNT_MIN || in_data.grading_factor == '0) begin
            state_next = gspg_pkg::F_PUSH;
          end else begin
            state_next = gspg_pkg::F_SQUARE;
          end
        end
      end
      gspg_pkg::F_SQUARE: begin
        if (sq_step == 2'd3) state_next = gspg_pkg::F_PUSH;
      end
      gspg_pkg::F_PUSH: begin
        if (push_ready) state_next = gspg_pkg::F_IDLE;
      end
      default: state_next = gspg_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == gspg_pkg::F_IDLE);
    push_valid = (state == gspg_pkg::F_PUSH);
    count_sat  = (item.point_count > gspg_pkg::COUNT_MAX) ? gspg_pkg::COUNT_MAX
                                                         : item.point_count;
    push_cmd.start_x    = item.start_x;
    push_cmd.start_y    = item.start_y;
    push_cmd.end_x      = item.end_x;
    push_cmd.end_y      = item.end_y;
    push_cmd.count      = gspg_pkg::IDX_BITS'(count_sat - gspg_pkg::COUNT_MIN);
    push_cmd.factor     = item.grading_factor;
    push_cmd.from_start = !degen && (item.grading_factor != gspg_pkg::FACTOR_ONE)
                          && (dist0 > dist1);
    push_cmd.degen      = degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gspg_pkg::F_IDLE;
      sq_step <= '0;
    end else begin
      state <= state_next;
      if (accept) sq_step <= '0;
      else if (state == gspg_pkg::F_SQUARE) sq_step <= sq_step + 2'd1;
    end
  end

  // payload capture and distance accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_data;
      degen   <= (in_data.point_count <= gspg_pkg::COUNT_MIN) || (in_data.grading_factor == '0);
      diff[0] <= {in_data.pick_x[gspg_pkg::COORD_BITS-1], in_data.pick_x}
               - {in_data.start_x[gspg_pkg::COORD_BITS-1], in_data.start_x};
      diff[1] <= {in_data.pick_y[gspg_pkg::COORD_BITS-1], in_data.pick_y}
               - {in_data.start_y[gspg_pkg::COORD_BITS-1], in_data.start_y};
      diff[2] <= {in_data.pick_x[gspg_pkg::COORD_BITS-1], in_data.pick_x}
               - {in_data.end_x[gspg_pkg::COORD_BITS-1], in_data.end_x};
      diff[3] <= {in_data.pick_y[gspg_pkg::COORD_BITS-1], in_data.pick_y}
               - {in_data.end_y[gspg_pkg::COORD_BITS-1], in_data.end_y};
    end else if (state == gspg_pkg::F_SQUARE) begin
      case (sq_step)
        2'd0: dist0 <= gspg_pkg::DIST_BITS'(square);
        2'd1: dist0 <= dist0 + gspg_pkg::DIST_BITS'(square);
        2'd2: dist1 <= gspg_pkg::DIST_BITS'(square);
        default: dist1 <= dist1 + gspg_pkg::DIST_BITS'(square);
      endcase
    end
  end

endmodule

>>> sv/gspg_queue.sv
// ----------------------------------------------------------------------------
// gspg_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module gspg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  gspg_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gspg_pkg::cmd_t pop_cmd
);

  gspg_pkg::cmd_t entry [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     fill;
  logic           do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

endmodule

>>> sv/gspg_back.sv
// ----------------------------------------------------------------------------
// gspg_back
// Builds the saturating power sums into a table, normalizes the total,
// divides both deltas bit-serially and emits the interior points.
// ----------------------------------------------------------------------------
module gspg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gspg_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output gspg_pkg::out_beat_t out_data
);

  localparam int PROD_LO_BITS = gspg_pkg::STEP_LO_BITS + gspg_pkg::GUARD_BITS;
  localparam int PROD_HI_BITS = gspg_pkg::STEP_HI_BITS + gspg_pkg::GUARD_BITS;
  localparam int ACC_BITS     = 64;

  gspg_pkg::back_state_t state, state_next;
  gspg_pkg::cmd_t        cur;

  logic [gspg_pkg::POW_BITS-1:0]   pre_mem [gspg_pkg::MAX_POINTS];
  logic [gspg_pkg::POW_BITS-1:0]   term, sum, norm, rdata;
  logic [gspg_pkg::IDX_BITS-1:0]   m, k;
  logic [gspg_pkg::SHIFT_BITS-1:0] sh;
  logic [gspg_pkg::DIVD_BITS-1:0]  dvd_x, dvd_y, q_x, q_y;
  logic [gspg_pkg::GUARD_BITS-1:0] rem_x, rem_y;
  logic [gspg_pkg::DIVC_BITS-1:0]  div_cnt;
  logic                            neg_x, neg_y;
  logic [PROD_LO_BITS-1:0]         plo_x, plo_y;
  logic [PROD_HI_BITS-1:0]         phi_x, phi_y;

  logic [2*gspg_pkg::POW_BITS-1:0] term_prod;
  logic [gspg_pkg::POW_BITS+3:0]   term_shift;
  logic [gspg_pkg::POW_BITS-1:0]   term_next;
  logic [gspg_pkg::POW_BITS:0]     sum_wide;
  logic [gspg_pkg::POW_BITS-1:0]   sum_next;
  logic signed [gspg_pkg::DIFF_BITS-1:0] delta_x, delta_y;
  logic [gspg_pkg::GUARD_BITS:0]   r_x, r_y;
  logic                            ge_x, ge_y;
  logic [gspg_pkg::IDX_BITS-1:0]   ridx;
  logic [gspg_pkg::GUARD_BITS-1:0] pn;
  logic [ACC_BITS-1:0]             acc_x, acc_y;
  logic [gspg_pkg::COORD_BITS-1:0] off_x, off_y, pt_x, pt_y;
  logic                            add_x, add_y;
  logic                            norm_done, div_done;

  // next power term and saturated running sum
  always_comb begin
    term_prod  = term * {{(2*gspg_pkg::POW_BITS-gspg_pkg::POW_BITS-gspg_pkg::FACTOR_BITS){1'b0}},
                         cur.factor};
    term_shift = (gspg_pkg::POW_BITS+4)'((term_prod + (2*gspg_pkg::POW_BITS)'(
                   gspg_pkg::POW_ONE >> 1)) >> gspg_pkg::FACTOR_FRAC_BITS);
    term_next  = (term_shift > (gspg_pkg::POW_BITS+4)'(gspg_pkg::POW_SAT))
                 ? gspg_pkg::POW_SAT : term_shift[gspg_pkg::POW_BITS-1:0];
    sum_wide   = {1'b0, sum} + {1'b0, term_next};
    sum_next   = sum_wide[gspg_pkg::POW_BITS] ? gspg_pkg::POW_SAT
                                              : sum_wide[gspg_pkg::POW_BITS-1:0];
  end

  // deltas, restoring divide step
  always_comb begin
    delta_x   = {cur.end_x[gspg_pkg::COORD_BITS-1], cur.end_x}
              - {cur.start_x[gspg_pkg::COORD_BITS-1], cur.start_x};
    delta_y   = {cur.end_y[gspg_pkg::COORD_BITS-1], cur.end_y}
              - {cur.start_y[gspg_pkg::COORD_BITS-1], cur.start_y};
    r_x       = {rem_x, dvd_x[gspg_pkg::DIVD_BITS-1]};
    r_y       = {rem_y, dvd_y[gspg_pkg::DIVD_BITS-1]};
    ge_x      = r_x >= {1'b0, norm[gspg_pkg::GUARD_BITS-1:0]};
    ge_y      = r_y >= {1'b0, norm[gspg_pkg::GUARD_BITS-1:0]};
    norm_done = (norm[gspg_pkg::POW_BITS-1:gspg_pkg::GUARD_BITS] == '0);
    div_done  = (div_cnt == gspg_pkg::DIVC_BITS'(gspg_pkg::DIVD_BITS - 1));
  end

  // point arithmetic
  always_comb begin
    ridx  = cur.from_start ? k : (cur.count - gspg_pkg::IDX_BITS'(1) - k);
    pn    = gspg_pkg::GUARD_BITS'(rdata >> sh);
    acc_x = ACC_BITS'(plo_x) + (ACC_BITS'(phi_x) << gspg_pkg::STEP_LO_BITS)
          + (ACC_BITS'(1) << (gspg_pkg::GUARD_BITS - 1));
    acc_y = ACC_BITS'(plo_y) + (ACC_BITS'(phi_y) << gspg_pkg::STEP_LO_BITS)
          + (ACC_BITS'(1) << (gspg_pkg::GUARD_BITS - 1));
    off_x = acc_x[gspg_pkg::GUARD_BITS +: gspg_pkg::COORD_BITS];
    off_y = acc_y[gspg_pkg::GUARD_BITS +: gspg_pkg::COORD_BITS];
    add_x = cur.from_start ^ neg_x;
    add_y = cur.from_start ^ neg_y;
    pt_x  = cur.from_start ? cur.start_x : cur.end_x;
    pt_y  = cur.from_start ? cur.start_y : cur.end_y;
    pt_x  = add_x ? pt_x + off_x : pt_x - off_x;
    pt_y  = add_y ? pt_y + off_y : pt_y - off_y;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gspg_pkg::B_IDLE: begin
        if (cmd_valid) state_next = cmd.degen ? gspg_pkg::B_OUT : gspg_pkg::B_POWER;
      end
      gspg_pkg::B_POWER: if (m == cur.count) state_next = gspg_pkg::B_NORM;
      gspg_pkg::B_NORM:  if (norm_done) state_next = gspg_pkg::B_DIV;
      gspg_pkg::B_DIV:   if (div_done) state_next = gspg_pkg::B_READ;
      gspg_pkg::B_READ:  state_next = gspg_pkg::B_MUL;
      gspg_pkg::B_MUL:   state_next = gspg_pkg::B_SUM;
      gspg_pkg::B_SUM:   state_next = gspg_pkg::B_OUT;
      gspg_pkg::B_OUT: begin
        if (out_ready) state_next = out_data.last ? gspg_pkg::B_IDLE : gspg_pkg::B_READ;
      end
      default: state_next = gspg_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready = (state == gspg_pkg::B_IDLE);
    out_valid = (state == gspg_pkg::B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gspg_pkg::B_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      gspg_pkg::B_IDLE: begin
        cur  <= cmd;
        term <= gspg_pkg::POW_ONE;
        sum  <= gspg_pkg::POW_ONE;
        m    <= '0;
        k    <= '0;
        // empty beat with only last set
        out_data <= {{(2*gspg_pkg::COORD_BITS+gspg_pkg::IDX_BITS+1){1'b0}}, 1'b1};
      end
      gspg_pkg::B_POWER: begin
        pre_mem[m] <= sum;
        norm       <= sum;
        sh         <= '0;
        if (m != cur.count) begin
          term <= term_next;
          sum  <= sum_next;
          m    <= m + gspg_pkg::IDX_BITS'(1);
        end
      end
      gspg_pkg::B_NORM: begin
        if (!norm_done) begin
          norm <= norm >> 1;
          sh   <= sh + gspg_pkg::SHIFT_BITS'(1);
        end
        neg_x   <= delta_x[gspg_pkg::DIFF_BITS-1];
        neg_y   <= delta_y[gspg_pkg::DIFF_BITS-1];
        dvd_x   <= {(delta_x[gspg_pkg::DIFF_BITS-1] ? gspg_pkg::DIFF_BITS'(-delta_x)
                                                    : gspg_pkg::DIFF_BITS'(delta_x)),
                    {gspg_pkg::GUARD_BITS{1'b0}}};
        dvd_y   <= {(delta_y[gspg_pkg::DIFF_BITS-1] ? gspg_pkg::DIFF_BITS'(-delta_y)
                                                    : gspg_pkg::DIFF_BITS'(delta_y)),
                    {gspg_pkg::GUARD_BITS{1'b0}}};
        rem_x   <= '0;
        rem_y   <= '0;
        q_x     <= '0;
        q_y     <= '0;
        div_cnt <= '0;
      end
      gspg_pkg::B_DIV: begin
        dvd_x   <= dvd_x << 1;
        dvd_y   <= dvd_y << 1;
        rem_x   <= ge_x ? gspg_pkg::GUARD_BITS'(r_x - {1'b0, norm[gspg_pkg::GUARD_BITS-1:0]})
                        : r_x[gspg_pkg::GUARD_BITS-1:0];
        rem_y   <= ge_y ? gspg_pkg::GUARD_BITS'(r_y - {1'b0, norm[gspg_pkg::GUARD_BITS-1:0]})
                        : r_y[gspg_pkg::GUARD_BITS-1:0];
        q_x     <= {q_x[gspg_pkg::DIVD_BITS-2:0], ge_x};
        q_y     <= {q_y[gspg_pkg::DIVD_BITS-2:0], ge_y};
        div_cnt <= div_cnt + gspg_pkg::DIVC_BITS'(1);
      end
      gspg_pkg::B_READ: rdata <= pre_mem[ridx];
      gspg_pkg::B_MUL: begin
        plo_x <= q_x[gspg_pkg::STEP_LO_BITS-1:0] * pn;
        plo_y <= q_y[gspg_pkg::STEP_LO_BITS-1:0] * pn;
        phi_x <= q_x[gspg_pkg::STEP_BITS-1:gspg_pkg::STEP_LO_BITS] * pn;
        phi_y <= q_y[gspg_pkg::STEP_BITS-1:gspg_pkg::STEP_LO_BITS] * pn;
      end
      gspg_pkg::B_SUM: begin
        out_data.point_x     <= pt_x;
        out_data.point_y     <= pt_y;
        out_data.point_index <= k;
        out_data.point_valid <= 1'b1;
        out_data.last        <= (k == cur.count - gspg_pkg::IDX_BITS'(1));
      end
      gspg_pkg::B_OUT: if (out_ready) k <= k + gspg_pkg::IDX_BITS'(1);
      default: ;
    endcase
  end

endmodule

>>> sv/graded_segment_point_generator_top.sv
// ----------------------------------------------------------------------------
// graded_segment_point_generator_top
// Geometric edge seeding: emits the graded interior points of a segment.
//
//   channel  direction  payload     handshake
//   in       sink       in_beat_t   in_valid / in_ready
//   out      source     out_beat_t  out_valid / out_ready
//
// The front accepts a beat and hands it off; a non-degenerate beat first takes
// four squares on one multiplier. The back per segment accepts, runs n-1 power
// steps, normalize shifts and 63 divide steps on a one-bit-per-cycle divider,
// then per point a table read, split multiply, sum and output, the output
// waiting on out_ready; a degenerate beat goes straight to one empty last beat.
// A two-entry queue lets the front classify ahead while the back works.
// Synchronous active-high reset clears the state machines and queue pointers.
// ----------------------------------------------------------------------------
module graded_segment_point_generator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gspg_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gspg_pkg::out_beat_t out_data
);

  gspg_pkg::cmd_t push_cmd, pop_cmd;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  // classify
  gspg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouple
  gspg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // generate points
  gspg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
